// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

// ===== hw/rtl/sll_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Static linked list package
// Sizes, codes and the control/status bundles shared by the controller,
// the datapath and the top level.
// ---------------------------------------------------------------------------
package sll_pkg;

   localparam int TABLE_SIZE = 16;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int CNT_W      = (IDX_W > 4) ? IDX_W : 4;
   localparam int POS_W      = 4;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int LEN_W      = 4;

   localparam logic [IDX_W-1:0] FREE_HEAD = '0;
   localparam logic [IDX_W-1:0] DATA_HEAD = IDX_W'(TABLE_SIZE - 1);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(TABLE_SIZE - 2);

   localparam logic ACT_DELETE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RD_FREE_HEAD = 2'd0,
      RD_DATA_HEAD = 2'd1,
      RD_LINK      = 2'd2
   } rd_sel_type;

   typedef enum logic [1:0] {
      WA_FREE_HEAD = 2'd0,
      WA_SLOT      = 2'd1,
      WA_PRED      = 2'd2
   } wa_sel_type;

   typedef enum logic {
      WD_LINK = 1'b0,
      WD_SLOT = 1'b1
   } wd_sel_type;

   typedef struct packed {
      logic       ld_req;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wa_sel_type wa_sel;
      wd_sel_type wd_sel;
      logic       elem_wr;
      logic       slot_ld;
      logic       cur_ld;
      logic       cur_head;
      logic       rem_init;
      logic       rem_dec;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       rsp_ld;
      status_type rsp_status;
   } ctl_cmd_type;

   typedef struct packed {
      logic pos_ok;
      logic is_delete;
      logic link_end;
      logic walk_last;
   } dp_stat_type;

   // Link table contents after reset: a free chain from slot 0 through the
   // second to last slot, and an empty data list.
   function automatic logic [IDX_W-1:0] reset_link(input logic [IDX_W-1:0] slot);
      logic [IDX_W-1:0] r;
      r = '0;
      if (int'(slot) + 2 < TABLE_SIZE) begin
         r = slot + IDX_W'(1);
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/sll_datapath.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Static linked list datapath
// Link table, element store, walk registers, element count and the
// response word register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sll_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  sll_pkg::ctl_cmd_type               ctl_cmd,
   output sll_pkg::dp_stat_type               dp_stat,
   input  logic                               req_action,
   input  logic [sll_pkg::POS_W-1:0]          req_position,
   input  logic signed [sll_pkg::VALUE_W-1:0] req_value,
   output logic [sll_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sll_pkg::LEN_W-1:0]          rsp_length
);
   import sll_pkg::*;

   logic                      action_ff;
   logic [POS_W-1:0]          pos_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [POS_W-1:0]          rem_ff, rem_in;
   logic [IDX_W-1:0]          cur_ff, cur_in;
   logic [IDX_W-1:0]          slot_ff, slot_in;
   logic [IDX_W-1:0]          rd_data_ff;
   logic [TABLE_SIZE-1:0]     link_vld_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [LEN_W-1:0]          rsp_length_ff;

   logic [IDX_W-1:0]          link_mem [TABLE_SIZE];
   logic signed [VALUE_W-1:0] elem_mem [TABLE_SIZE];

   logic [IDX_W-1:0]          rd_addr;
   logic [IDX_W-1:0]          wr_addr;
   logic [IDX_W-1:0]          wr_data;
   logic [CNT_W:0]            pos_ext;
   logic [CNT_W:0]            limit;

   always_comb begin
      cnt_in = cnt_ff;
      if (ctl_cmd.cnt_inc) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (ctl_cmd.cnt_dec) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end

      rem_in = rem_ff;
      if (ctl_cmd.rem_init) begin
         rem_in = pos_ff - POS_W'(1);
      end else if (ctl_cmd.rem_dec) begin
         rem_in = rem_ff - POS_W'(1);
      end

      cur_in = cur_ff;
      if (ctl_cmd.cur_ld) begin
         cur_in = ctl_cmd.cur_head ? DATA_HEAD : rd_data_ff;
      end

      slot_in = ctl_cmd.slot_ld ? rd_data_ff : slot_ff;
   end

   always_comb begin
      case (ctl_cmd.rd_sel)
         RD_FREE_HEAD: rd_addr = FREE_HEAD;
         RD_DATA_HEAD: rd_addr = DATA_HEAD;
         RD_LINK:      rd_addr = rd_data_ff;
         default:      rd_addr = FREE_HEAD;
      endcase

      case (ctl_cmd.wa_sel)
         WA_FREE_HEAD: wr_addr = FREE_HEAD;
         WA_SLOT:      wr_addr = slot_ff;
         WA_PRED:      wr_addr = cur_ff;
         default:      wr_addr = FREE_HEAD;
      endcase

      case (ctl_cmd.wd_sel)
         WD_LINK: wr_data = rd_data_ff;
         WD_SLOT: wr_data = slot_ff;
         default: wr_data = rd_data_ff;
      endcase
   end

   // Insert accepts positions up to length+1, delete only up to length.
   assign pos_ext = (CNT_W+1)'(pos_ff);
   assign limit   = (action_ff == ACT_DELETE) ? (CNT_W+1)'(cnt_ff)
                                              : (CNT_W+1)'(cnt_ff) + (CNT_W+1)'(1);

   always_comb begin
      dp_stat.pos_ok    = (pos_ff != '0) && (pos_ext <= limit);
      dp_stat.is_delete = (action_ff == ACT_DELETE);
      dp_stat.link_end  = (rd_data_ff == FREE_HEAD) || (rd_data_ff == DATA_HEAD);
      dp_stat.walk_last = (rem_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         link_vld_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (ctl_cmd.wr_en) begin
            link_vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.ld_req) begin
         action_ff <= req_action;
         pos_ff    <= req_position;
         value_ff  <= req_value;
      end
      rem_ff  <= rem_in;
      cur_ff  <= cur_in;
      slot_ff <= slot_in;
      if (ctl_cmd.rsp_ld) begin
         rsp_status_ff <= ctl_cmd.rsp_status;
         rsp_length_ff <= cnt_ff[LEN_W-1:0];
      end
   end

   // A slot never written since reset reads as its reset link.
   always_ff @(posedge clock) begin
      if (ctl_cmd.rd_en) begin
         rd_data_ff <= link_vld_ff[rd_addr] ? link_mem[rd_addr] : reset_link(rd_addr);
      end
      if (ctl_cmd.wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (ctl_cmd.elem_wr) begin
         elem_mem[slot_ff] <= value_ff;
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_length = rsp_length_ff;

   `ASSERT_CLK(a_cnt_bound, clock, reset, cnt_ff <= MAX_COUNT, "element count above capacity")
   `ASSERT_NEVER(a_inc_full, clock, reset, ctl_cmd.cnt_inc && (cnt_ff == MAX_COUNT), "insert into full table")
   `ASSERT_NEVER(a_dec_empty, clock, reset, ctl_cmd.cnt_dec && (cnt_ff == '0), "delete from empty list")

endmodule

// ===== hw/rtl/sll_controller.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Static linked list controller
// Sequences the range check, free list access, link walk and relinking,
// and owns the request and response handshakes.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sll_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sll_pkg::ctl_cmd_type  ctl_cmd,
   input  sll_pkg::dp_stat_type  dp_stat
);
   import sll_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE       = 12'h001,
      S_CHECK      = 12'h002,
      S_INS_FREE   = 12'h004,
      S_INS_UNLINK = 12'h008,
      S_WALK_FIRST = 12'h010,
      S_WALK       = 12'h020,
      S_AT_PRED    = 12'h040,
      S_INS_HOOK   = 12'h080,
      S_DEL_BYPASS = 12'h100,
      S_DEL_FREE   = 12'h200,
      S_DEL_PUSH   = 12'h400,
      S_DONE       = 12'h800
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      ctl_cmd            = '0;
      ctl_cmd.rd_sel     = RD_FREE_HEAD;
      ctl_cmd.wa_sel     = WA_FREE_HEAD;
      ctl_cmd.wd_sel     = WD_LINK;
      ctl_cmd.rsp_status = status_ff;
      state_in           = state_ff;
      status_in          = status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl_cmd.ld_req = 1'b1;
               state_in       = S_CHECK;
            end
         end
         S_CHECK: begin
            ctl_cmd.rem_init = 1'b1;
            if (!dp_stat.pos_ok) begin
               status_in = ST_RANGE;
               state_in  = S_DONE;
            end else if (dp_stat.is_delete) begin
               state_in = S_WALK_FIRST;
            end else begin
               ctl_cmd.rd_en  = 1'b1;
               ctl_cmd.rd_sel = RD_FREE_HEAD;
               state_in       = S_INS_FREE;
            end
         end
         S_INS_FREE: begin
            if (dp_stat.link_end) begin
               status_in = ST_FULL;
               state_in  = S_DONE;
            end else begin
               ctl_cmd.slot_ld = 1'b1;
               ctl_cmd.rd_en   = 1'b1;
               ctl_cmd.rd_sel  = RD_LINK;
               state_in        = S_INS_UNLINK;
            end
         end
         S_INS_UNLINK: begin
            // Free head moves on to the slot after the one taken.
            ctl_cmd.wr_en   = 1'b1;
            ctl_cmd.wa_sel  = WA_FREE_HEAD;
            ctl_cmd.wd_sel  = WD_LINK;
            ctl_cmd.elem_wr = 1'b1;
            state_in        = S_WALK_FIRST;
         end
         S_WALK_FIRST: begin
            ctl_cmd.rd_en    = 1'b1;
            ctl_cmd.rd_sel   = RD_DATA_HEAD;
            ctl_cmd.cur_ld   = 1'b1;
            ctl_cmd.cur_head = 1'b1;
            if (dp_stat.walk_last) begin
               state_in = S_AT_PRED;
            end else begin
               ctl_cmd.rem_dec = 1'b1;
               state_in        = S_WALK;
            end
         end
         S_WALK: begin
            // The link just read becomes the current slot and is read in turn.
            ctl_cmd.rd_en  = 1'b1;
            ctl_cmd.rd_sel = RD_LINK;
            ctl_cmd.cur_ld = 1'b1;
            if (dp_stat.walk_last) begin
               state_in = S_AT_PRED;
            end else begin
               ctl_cmd.rem_dec = 1'b1;
            end
         end
         S_AT_PRED: begin
            if (!dp_stat.is_delete) begin
               ctl_cmd.wr_en  = 1'b1;
               ctl_cmd.wa_sel = WA_SLOT;
               ctl_cmd.wd_sel = WD_LINK;
               state_in       = S_INS_HOOK;
            end else if (dp_stat.link_end) begin
               status_in = ST_RANGE;
               state_in  = S_DONE;
            end else begin
               ctl_cmd.slot_ld = 1'b1;
               ctl_cmd.rd_en   = 1'b1;
               ctl_cmd.rd_sel  = RD_LINK;
               state_in        = S_DEL_BYPASS;
            end
         end
         S_INS_HOOK: begin
            ctl_cmd.wr_en   = 1'b1;
            ctl_cmd.wa_sel  = WA_PRED;
            ctl_cmd.wd_sel  = WD_SLOT;
            ctl_cmd.cnt_inc = 1'b1;
            status_in       = ST_OK;
            state_in        = S_DONE;
         end
         S_DEL_BYPASS: begin
            ctl_cmd.wr_en  = 1'b1;
            ctl_cmd.wa_sel = WA_PRED;
            ctl_cmd.wd_sel = WD_LINK;
            ctl_cmd.rd_en  = 1'b1;
            ctl_cmd.rd_sel = RD_FREE_HEAD;
            state_in       = S_DEL_FREE;
         end
         S_DEL_FREE: begin
            ctl_cmd.wr_en  = 1'b1;
            ctl_cmd.wa_sel = WA_SLOT;
            ctl_cmd.wd_sel = WD_LINK;
            state_in       = S_DEL_PUSH;
         end
         S_DEL_PUSH: begin
            ctl_cmd.wr_en   = 1'b1;
            ctl_cmd.wa_sel  = WA_FREE_HEAD;
            ctl_cmd.wd_sel  = WD_SLOT;
            ctl_cmd.cnt_dec = 1'b1;
            status_in       = ST_OK;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl_cmd.rsp_ld = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl_cmd.rsp_ld) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // No word is taken while reset is held.
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_CLK(a_accept_check, clock, reset, (req_valid && req_ready) |=> (state_ff == S_CHECK), "accepted word not checked next")
   `ASSERT_CLK(a_rsp_slot_free, clock, reset, ctl_cmd.rsp_ld |-> (!rsp_valid_ff || rsp_ready), "response overwrites pending word")
   `ASSERT_NEVER(a_idle_write, clock, reset, ((state_ff == S_IDLE) || (state_ff == S_DONE)) && ctl_cmd.wr_en, "link write outside an operation")

endmodule

// ===== hw/rtl/static_linked_list_engine_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Static linked list engine
// Array-backed singly linked list with a free list; inserts or deletes at a
// 1-based position and answers with a status and the new length.
//
//   Channel   Dir   Handshake              Word fields
//   req       in    req_valid/req_ready    action, position, value
//   rsp       out   rsp_valid/rsp_ready    status, length
//
// The walk through the link table reads one link per cycle on its single
// registered read port.
// Reset is synchronous; the link table reads its reset contents through
// per-slot valid bits, so no clearing pass is needed.
// A stalled response holds the finished item; the next one is accepted
// only after the response register has been loaded.
// ---------------------------------------------------------------------------
module static_linked_list_engine_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_action,
   input  logic [sll_pkg::POS_W-1:0]          req_position,
   input  logic signed [sll_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sll_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sll_pkg::LEN_W-1:0]          rsp_length
);
   import sll_pkg::*;

   ctl_cmd_type ctl_cmd;
   dp_stat_type dp_stat;

   sll_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl_cmd   (ctl_cmd),
      .dp_stat   (dp_stat)
   );

   sll_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctl_cmd      (ctl_cmd),
      .dp_stat      (dp_stat),
      .req_action   (req_action),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_status   (rsp_status),
      .rsp_length   (rsp_length)
   );

endmodule
